[rtl/core/streaming_top_k_kth_largest_defines.svh]
// Assertion macros for the streaming top-k selection block.
// No dependencies; taken in by the top level with `include.
`ifndef STREAMING_TOP_K_KTH_LARGEST_DEFINES_SVH
`define STREAMING_TOP_K_KTH_LARGEST_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define TKK_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define TKK_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/tkk_pkg.sv]
// Shared types and constants for the streaming top-k selection block.
// No dependencies.
package tkk_pkg;

   localparam int DATA_W        = 32;
   localparam int RANK_W        = 5;
   localparam int MAX_RANK_DEF  = 16;
   localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(1);

   // Control from the pipeline to the sorted store
   typedef struct packed {
      logic update;        // take the staged value this cycle
      logic end_of_array;  // report and empty the store after the insert
   } tkk_store_ctrl_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] kth_value;
      logic                     rank_reached;
   } tkk_result_type;

endpackage

[rtl/core/tkk_if.sv]
// Valid/ready channel interfaces for request and response transactions.
// Depends on tkk_pkg.
interface tkk_req_if import tkk_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] sample_value;
   logic                     end_of_array;

   modport source (output valid, output sample_value, output end_of_array, input ready);
   modport sink   (input valid, input sample_value, input end_of_array, output ready);
endinterface

interface tkk_rsp_if import tkk_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] kth_value;
   logic                     rank_reached;

   modport source (output valid, output kth_value, output rank_reached, input ready);
   modport sink   (input valid, input kth_value, input rank_reached, output ready);
endinterface

[rtl/core/tkk_store.sv]
// Sorted compare-and-shift register file holding the largest values seen.
// Depends on tkk_pkg.
module tkk_store import tkk_pkg::*; #(
   parameter int MAX_RANK = MAX_RANK_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tkk_store_ctrl_type       ctrl,
   input  logic signed [DATA_W-1:0] sample_value,
   input  logic [RANK_W-1:0]        rank_k,
   output tkk_result_type           result
);

   localparam int CNT_W = $clog2(MAX_RANK + 1);
   localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

   logic signed [DATA_W-1:0] kept_ff [MAX_RANK];
   logic signed [DATA_W-1:0] kept_in [MAX_RANK];
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic [CNT_W-1:0]         count_after;
   logic [MAX_RANK-1:0]      take;
   logic [CMP_W-1:0]         rank_eff;
   logic [CMP_W-1:0]         rank_m1;
   logic signed [DATA_W-1:0] sel_value;

   // take[i]: new value lands at or above slot i; monotone along the array
   genvar g;
   generate
      for (g = 0; g < MAX_RANK; g++) begin : g_slot
         always_comb begin
            take[g] = (CNT_W'(g) >= count_ff) || (sample_value > kept_ff[g]);
         end
         if (g == 0) begin : g_head
            always_comb begin
               kept_in[g] = take[g] ? sample_value : kept_ff[g];
            end
         end else begin : g_body
            always_comb begin
               if (!take[g])
                  kept_in[g] = kept_ff[g];
               else if (!take[g-1])
                  kept_in[g] = sample_value;
               else
                  kept_in[g] = kept_ff[g-1];
            end
         end
      end
   endgenerate

   // A full store that drops the value keeps its count, so it saturates either way
   assign count_after = (count_ff == CNT_W'(MAX_RANK)) ? count_ff : count_ff + CNT_W'(1);
   assign count_in    = ctrl.end_of_array ? '0 : count_after;

   always_ff @(posedge clock) begin
      if (ctrl.update) begin
         for (int i = 0; i < MAX_RANK; i++) begin
            kept_ff[i] <= kept_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.update) begin
         count_ff <= count_in;
      end
   end

   // Rank zero behaves as rank one
   assign rank_eff = (rank_k == '0) ? CMP_W'(1) : CMP_W'(rank_k);
   assign rank_m1  = rank_eff - CMP_W'(1);

   always_comb begin
      sel_value = '0;
      for (int i = 0; i < MAX_RANK; i++) begin
         if (CMP_W'(i) == rank_m1)
            sel_value = kept_in[i];
      end
   end

   always_comb begin
      result.rank_reached = (rank_eff <= CMP_W'(MAX_RANK)) &&
                            (CMP_W'(count_after) >= rank_eff);
      result.kth_value    = result.rank_reached ? sel_value : '0;
   end

endmodule

[rtl/core/streaming_top_k_kth_largest.sv]
// Top level of the streaming top-k selection block: input stage, store, result stage.
// Depends on tkk_pkg, tkk_if (tkk_req_if, tkk_rsp_if), tkk_store and the defines header.
//
//   channel  | direction | payload                       | handshake
//   ---------+-----------+-------------------------------+----------------------
//   req_if   | in        | sample_value, end_of_array    | valid / ready
//   rsp_if   | out       | kth_value, rank_reached       | valid / ready
//   csr_*    | in        | rank_k (5 bits)               | csr_wr_en, no wait
//
// One transaction per cycle; a waiting result stalls only a following end-of-array
// element, and other elements keep flowing. The result register captures the store
// result as the last element leaves the input register. The store updates from the
// input register in one pass of compare-and-shift logic. Synchronous reset empties the
// store and sets rank_k to one; stored values need no reset.
`include "streaming_top_k_kth_largest_defines.svh"

module streaming_top_k_kth_largest import tkk_pkg::*; #(
   parameter int MAX_RANK = MAX_RANK_DEF
) (
   input  logic              clock,
   input  logic              reset,
   tkk_req_if.sink           req_if,
   tkk_rsp_if.source         rsp_if,
   input  logic              csr_wr_en,
   input  logic [RANK_W-1:0] csr_wr_data
);

   logic                     a_valid_ff;
   logic signed [DATA_W-1:0] a_value_ff;
   logic                     a_last_ff;
   logic                     a_adv;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   tkk_result_type           rsp_data_ff;
   tkk_result_type           store_result;
   tkk_store_ctrl_type       store_ctrl;
   logic [RANK_W-1:0]        rank_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= RANK_RESET;
      end else if (csr_wr_en) begin
         rank_ff <= csr_wr_data;
      end
   end

   // A last element needs the result register free (or draining) to move on
   assign a_adv = a_valid_ff && !(a_last_ff && rsp_valid_ff && !rsp_if.ready);
   assign req_if.ready = !a_valid_ff || a_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         a_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         a_value_ff <= req_if.sample_value;
         a_last_ff  <= req_if.end_of_array;
      end
   end

   always_comb begin
      store_ctrl.update       = a_adv;
      store_ctrl.end_of_array = a_last_ff;
   end

   tkk_store #(
      .MAX_RANK (MAX_RANK)
   ) u_store (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (store_ctrl),
      .sample_value (a_value_ff),
      .rank_k       (rank_ff),
      .result       (store_result)
   );

   always_comb begin
      if (a_adv && a_last_ff)
         rsp_valid_in = 1'b1;
      else if (rsp_if.ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv && a_last_ff) begin
         rsp_data_ff <= store_result;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.kth_value    = rsp_data_ff.kth_value;
   assign rsp_if.rank_reached = rsp_data_ff.rank_reached;

   `TKK_ASSERT_NXT(a_last_gives_rsp, clock, reset, a_adv && a_last_ff, rsp_valid_ff, "end of array gave no result")
   `TKK_ASSERT_IMP(a_last_no_overrun, clock, reset, a_adv && a_last_ff, !rsp_valid_ff || rsp_if.ready, "result overwritten before taken")
   `TKK_ASSERT_NXT(a_mid_keeps_rsp, clock, reset, a_adv && !a_last_ff && rsp_valid_ff && !rsp_if.ready, rsp_valid_ff, "mid-array element disturbed waiting result")

endmodule
